FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: design/dpfrc_pkg.sv
// Types and constants of the deduplicating packet FIFO with range count.
// No dependencies.
package dpfrc_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int LIMIT_W = 7;
	localparam int COUNT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_FWD = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [15:0] in_source;
		logic [15:0] in_destination;
		logic [31:0] in_timestamp;
		logic [31:0] start_time;
		logic [31:0] end_time;
	} req_t;

	typedef struct packed {
		logic added;
		logic out_valid;
		logic [15:0] out_source;
		logic [15:0] out_destination;
		logic [31:0] out_timestamp;
		logic [COUNT_W-1:0] match_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
	} pkt_t;

	typedef struct packed {
		logic clr;
		logic [LIMIT_W-1:0] limit;
	} ctrl_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

FILE: design/dpfrc_ram.sv
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
module dpfrc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/dpfrc_ctrl.sv
// Queue controller: pointers, occupancy, slot scan, command sequencing.
// Depends on dpfrc_pkg; drives the slot RAM instanced in the top level.
module dpfrc_ctrl
	import dpfrc_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input ctrl_cfg_t cfg,
	input logic start,
	input req_t req,
	output logic busy,
	output logic res_valid,
	input logic res_ready,
	output rsp_t res,
	output logic ram_we,
	output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_waddr,
	output pkt_t ram_wdata,
	output logic ram_re,
	output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_raddr,
	input pkt_t ram_rdata
);

	localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = OCC_W > LIMIT_W ? OCC_W : LIMIT_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(QUEUE_DEPTH);

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	pkt_t pkt_q;
	logic [31:0] lo_q, hi_q;
	logic [PTR_W-1:0] rp_q, wp_q, scan_ptr_q;
	logic [OCC_W-1:0] occ_q, issued_q, len_q, len_d;
	logic rd_s1;
	logic dup_q;
	logic [COUNT_W-1:0] cnt_q;
	pkt_t fwd_q;
	logic issue, commit, full, match_dup, match_cnt;
	logic [CMP_W-1:0] lim_raw, eff_lim;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		lim_raw = CMP_W'(cfg.limit);
		eff_lim = lim_raw;
		if (lim_raw == '0) begin
			eff_lim = CMP_W'(1);
		end else if (lim_raw > DEPTH_C) begin
			eff_lim = DEPTH_C;
		end
	end

	assign full = CMP_W'(occ_q) >= eff_lim;
	assign issue = (state_q == ST_SCAN) && (issued_q != len_q);
	assign match_dup = (ram_rdata == pkt_q);
	assign match_cnt = (ram_rdata.destination == pkt_q.destination)
		&& (ram_rdata.timestamp >= lo_q) && (ram_rdata.timestamp <= hi_q);

	always_comb begin
		unique case (req.cmd)
			CMD_ADD, CMD_COUNT: len_d = occ_q;
			CMD_FWD: len_d = OCC_W'(occ_q != '0);
			default: len_d = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		res_valid = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res = '0;
		unique case (cmd_q)
			CMD_ADD: res.added = !dup_q;
			CMD_FWD: begin
				if (occ_q != '0) begin
					res.out_valid = 1'b1;
					res.out_source = fwd_q.source;
					res.out_destination = fwd_q.destination;
					res.out_timestamp = fwd_q.timestamp;
				end
			end
			CMD_COUNT: res.match_count = cnt_q;
			default: res = '0;
		endcase
	end

	assign ram_re = issue;
	assign ram_raddr = scan_ptr_q;
	assign ram_we = commit && (cmd_q == CMD_ADD) && !dup_q;
	assign ram_waddr = wp_q;
	assign ram_wdata = pkt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1 <= issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			occ_q <= '0;
		end else if (cfg.clr) begin
			rp_q <= '0;
			wp_q <= '0;
			occ_q <= '0;
		end else if (commit) begin
			if (ram_we) begin
				wp_q <= next_ptr(wp_q);
				if (full) begin
					rp_q <= next_ptr(rp_q);
				end else begin
					occ_q <= occ_q + 1'b1;
				end
			end else if (cmd_q == CMD_FWD && occ_q != '0) begin
				rp_q <= next_ptr(rp_q);
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			cmd_q <= req.cmd;
			pkt_q <= '{source: req.in_source, destination: req.in_destination,
				timestamp: req.in_timestamp};
			lo_q <= req.start_time;
			hi_q <= req.end_time;
			scan_ptr_q <= rp_q;
			issued_q <= '0;
			len_q <= len_d;
			dup_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (issue) begin
				scan_ptr_q <= next_ptr(scan_ptr_q);
				issued_q <= issued_q + 1'b1;
			end
			if (rd_s1) begin
				fwd_q <= ram_rdata;
				if (match_dup) begin
					dup_q <= 1'b1;
				end
				if (match_cnt && cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: design/dedup_packet_fifo_with_range_count_top.sv
// Top level of the deduplicating packet FIFO with range count.
// Depends on dpfrc_pkg, dpfrc_ram, dpfrc_ctrl and assert_macros.svh.
//
// Usage:
//   req channel (req_valid/req_stall/req) takes one command beat: add, forward
//   or count. rsp channel (rsp_valid/rsp_stall/rsp) returns one result beat
//   per command. cfg channel (cfg_valid/cfg_ready/cfg_data) writes the queue
//   limit and empties the queue; write it only while no command is pending.
//   Packets live in one slot RAM; add and count read every queued slot, one
//   slot per cycle, forward reads the oldest slot of a non-empty queue.
//   A command scans its slots in the scan state, then offers its result in the
//   finish state; the result enters the output register once that register
//   is free, and the next command is taken once the controller is back in
//   idle. The scan is serial because the slot RAM has a single read port.
//   Reset empties the queue and sets the limit to 64; slot contents are not
//   cleared. While the receiver stalls, the result waits in the output
//   register and one further command may run; its result then waits until
//   the register frees.
`include "assert_macros.svh"

module dedup_packet_fifo_with_range_count_top
	import dpfrc_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LIMIT_W-1:0] cfg_data
);

	localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;

	logic [LIMIT_W-1:0] limit_q;
	logic rsp_full_q;
	rsp_t rsp_q;
	ctrl_cfg_t cfg;
	logic busy, start, cfg_write;
	logic res_valid, res_ready;
	rsp_t res;
	logic ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	pkt_t ram_wdata, ram_rdata;

	assign cfg_ready = !busy;
	assign cfg_write = cfg_valid && cfg_ready;
	assign req_stall = busy || cfg_valid;
	assign start = req_valid && !req_stall;
	assign cfg = '{clr: cfg_write, limit: limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	assign res_ready = !rsp_full_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_full_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_full_q;
	assign rsp = rsp_q;

	dpfrc_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.start(start),
		.req(req),
		.busy(busy),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	dpfrc_ram #(
		.WIDTH($bits(pkt_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`ASSERT_IMP(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re)
	`ASSERT_IMP(a_result_while_busy, clk, arst_n, res_valid, busy)
	`ASSERT_NXT(a_start_busy, clk, arst_n, start, busy)
	`ASSERT_NXT(a_write_ends_cmd, clk, arst_n, ram_we, !busy && rsp_full_q)

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench of dedup_packet_fifo_with_range_count_top: directed and random add, forward and
// count commands, each result beat checked against a queue predictor kept in a scoreboard.
// Depends on dpfrc_pkg and the design files under design/.
module testbench;
	import dpfrc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned SETTLE_CYCLES = DEF_QUEUE_DEPTH + 8;
	localparam int unsigned PHASES = 10;
	localparam int unsigned PHASE_ITEMS = 125;

	class dedup_fifo_scoreboard;
		pkt_t slots[DEF_QUEUE_DEPTH];
		int unsigned head, tail, fill;
		logic [LIMIT_W-1:0] limit;
		rsp_t pending_results[$];
		int unsigned errors;

		function new();
			limit = LIMIT_RESET;
			head = 0;
			tail = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] v);
			limit = v;
			head = 0;
			tail = 0;
			fill = 0;
		endfunction

		function void drop_oldest();
			head = (head + 1) % DEF_QUEUE_DEPTH;
			fill--;
		endfunction

		function void note_command(req_t r);
			rsp_t e;
			pkt_t pk;
			int unsigned p, cap, n;
			logic dup;
			e = '0;
			pk.source = r.in_source;
			pk.destination = r.in_destination;
			pk.timestamp = r.in_timestamp;
			case (r.cmd)
				CMD_ADD: begin
					dup = 1'b0;
					p = head;
					for (int unsigned i = 0; i < fill; i++) begin
						if (slots[p] == pk)
							dup = 1'b1;
						p = (p + 1) % DEF_QUEUE_DEPTH;
					end
					if (!dup) begin
						cap = (limit == 0) ? 1 :
							(limit > DEF_QUEUE_DEPTH) ? DEF_QUEUE_DEPTH : limit;
						while (fill >= cap)
							drop_oldest();
						slots[tail] = pk;
						tail = (tail + 1) % DEF_QUEUE_DEPTH;
						fill++;
						e.added = 1'b1;
					end
				end
				CMD_FWD: begin
					if (fill > 0) begin
						e.out_valid = 1'b1;
						e.out_source = slots[head].source;
						e.out_destination = slots[head].destination;
						e.out_timestamp = slots[head].timestamp;
						drop_oldest();
					end
				end
				CMD_COUNT: begin
					n = 0;
					p = head;
					for (int unsigned i = 0; i < fill; i++) begin
						if (slots[p].destination == r.in_destination &&
							slots[p].timestamp >= r.start_time &&
							slots[p].timestamp <= r.end_time && n < COUNT_MAX)
							n++;
						p = (p + 1) % DEF_QUEUE_DEPTH;
					end
					e.match_count = COUNT_W'(n);
				end
				default: ;
			endcase
			pending_results.push_back(e);
		endfunction

		function void compare(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending_results.size() == 0) begin
				$error("result beat with no command waiting: %h", got);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare("added", 32'(e.added), 32'(got.added));
			compare("out_valid", 32'(e.out_valid), 32'(got.out_valid));
			compare("out_source", 32'(e.out_source), 32'(got.out_source));
			compare("out_destination", 32'(e.out_destination), 32'(got.out_destination));
			compare("out_timestamp", e.out_timestamp, got.out_timestamp);
			compare("match_count", 32'(e.match_count), 32'(got.match_count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	dedup_fifo_scoreboard board = new();

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit long_hold_req = 1'b0;
	logic [15:0] src_pool[4];
	logic [15:0] dst_pool[4];
	int unsigned ts_now;
	pkt_t recent[$];

	dedup_packet_fifo_with_range_count_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic req_t make_req(logic [1:0] cmd, logic [15:0] src, logic [15:0] dst,
		logic [31:0] ts, logic [31:0] lo, logic [31:0] hi);
		req_t r;
		r.cmd = cmd;
		r.in_source = src;
		r.in_destination = dst;
		r.in_timestamp = ts;
		r.start_time = lo;
		r.end_time = hi;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		pkt_t pk;
		int unsigned pick;
		logic [31:0] lo;
		r = make_req(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			r.cmd = CMD_UNUSED;
		end else if (pick < 55) begin
			r.cmd = CMD_ADD;
			if (recent.size() > 0 && $urandom_range(0, 5) == 0) begin
				pk = recent[$urandom_range(0, recent.size() - 1)];
			end else begin
				pk.source = ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: src_pool[$urandom_range(0, 3)];
				pk.destination = ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: dst_pool[$urandom_range(0, 3)];
				if ($urandom_range(0, 9) == 0) begin
					pk.timestamp = $urandom;
				end else begin
					ts_now += $urandom_range(0, 2);
					pk.timestamp = ts_now;
				end
				recent.push_back(pk);
				if (recent.size() > 16)
					void'(recent.pop_front());
			end
			r.in_source = pk.source;
			r.in_destination = pk.destination;
			r.in_timestamp = pk.timestamp;
		end else if (pick < 75) begin
			r.cmd = CMD_FWD;
		end else begin
			r.cmd = CMD_COUNT;
			if ($urandom_range(0, 7) != 0)
				r.in_destination = dst_pool[$urandom_range(0, 3)];
			lo = ts_now - $urandom_range(0, 20);
			case ($urandom_range(0, 3))
				0: begin
					r.start_time = '0;
					r.end_time = '1;
				end
				1: begin
					r.start_time = lo;
					r.end_time = lo + $urandom_range(0, 20);
				end
				2: begin
					r.start_time = lo;
					r.end_time = lo - $urandom_range(1, 10);
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic send(input req_t r);
		int unsigned gap;
		gap = (!tx_quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		board.note_command(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_limit(v);
	endtask

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);

	initial begin : rsp_side
		int unsigned stall_left, run_left;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
				run_left = 0;
			end
			if (stall_left == 0 && run_left == 0 && !rx_quiet) begin
				if ($urandom_range(0, 2) == 0)
					stall_left = $urandom_range(1, 18);
				else
					run_left = $urandom_range(1, 40);
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (run_left > 0)
					run_left--;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("dedup_packet_fifo_with_range_count_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [LIMIT_W-1:0] phase_limit[PHASES];
		phase_limit = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd64, 7'd2, 7'd33, 7'd127, 7'd64};
		phase_limit[7] = LIMIT_W'($urandom_range(3, 63));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unknown command, extremes, duplicate, inclusive bounds
		send(make_req(CMD_FWD, '1, '1, '1, '1, '1));
		send(make_req(CMD_COUNT, '0, '0, '0, '0, '1));
		send(make_req(CMD_UNUSED, '1, '1, '1, '1, '1));
		send(make_req(CMD_ADD, '0, '0, '0, '1, '1));
		send(make_req(CMD_ADD, '1, '1, '1, '0, '0));
		send(make_req(CMD_ADD, '1, '1, '1, '0, '0));
		send(make_req(CMD_ADD, '1, '1, 32'hFFFF_FFFE, '0, '0));
		send(make_req(CMD_COUNT, '0, '1, '0, '0, '1));
		send(make_req(CMD_COUNT, '0, '1, '0, '1, '1));
		send(make_req(CMD_COUNT, '0, '1, '0, '1, 32'hFFFF_FFFE));
		send(make_req(CMD_COUNT, '0, '0, '0, '0, '0));
		send(make_req(CMD_FWD, '0, '0, '0, '0, '0));
		send(make_req(CMD_ADD, '0, '0, '0, '0, '0));

		// evict oldest at a small limit, then clear the queue by a limit write
		wait_drained();
		write_limit(7'd2);
		send(make_req(CMD_ADD, 16'h1, 16'h7, 32'd10, '0, '0));
		send(make_req(CMD_ADD, 16'h2, 16'h7, 32'd11, '0, '0));
		send(make_req(CMD_ADD, 16'h3, 16'h7, 32'd12, '0, '0));
		send(make_req(CMD_COUNT, '0, 16'h7, '0, 32'd10, 32'd12));
		send(make_req(CMD_FWD, '0, '0, '0, '0, '0));
		wait_drained();
		write_limit(7'd0);
		send(make_req(CMD_FWD, '0, '0, '0, '0, '0));
		send(make_req(CMD_ADD, 16'h4, 16'h8, 32'd20, '0, '0));
		send(make_req(CMD_ADD, 16'h5, 16'h8, 32'd21, '0, '0));
		send(make_req(CMD_FWD, '0, '0, '0, '0, '0));
		send(make_req(CMD_FWD, '0, '0, '0, '0, '0));

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_limit(phase_limit[ph]);
			foreach (src_pool[i]) src_pool[i] = 16'($urandom);
			foreach (dst_pool[i]) dst_pool[i] = 16'($urandom);
			src_pool[0] = (ph % 2) ? '1 : '0;
			dst_pool[0] = (ph % 2) ? '0 : '1;
			case (ph % 3)
				0: ts_now = $urandom_range(0, 1000);
				1: ts_now = $urandom;
				default: ts_now = 32'hFFFF_FFF0;
			endcase
			if (ph == PHASES - 1) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end
			if (ph == 5) begin
				tx_quiet = 1'b1;
				long_hold_req = 1'b1;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph != PHASES - 1 && k % 40 == 39)
					tx_quiet = ($urandom_range(0, 2) == 0);
				send(random_req());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("dedup_packet_fifo_with_range_count_top test passed");
		else
			$display("dedup_packet_fifo_with_range_count_top test failed");
		$finish;
	end

endmodule
